### rtl/fbc_pkg.sv
// Shared types, constants and helpers for the frustum box cull block.
`default_nettype none

package fbc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SLOT_W      = 32;
    localparam int REG_W       = 64;
    localparam int NUM_REGS    = 8;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int ADDR_W      = REG_IDX_W + 3;
    localparam int NUM_PLANES  = 6;
    localparam int COEF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = COEF_W + COORD_WIDTH;
    localparam int SUM_W       = PROD_W + 2;

    localparam int KIND_W      = 2;
    localparam int BOX_DATA_W  = 6 * 32;
    localparam int OUT_DATA_W  = 8;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROW0_XY = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_ZW = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_XY = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_ZW = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_XY = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_ZW = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_XY = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_ZW = 3'd7;

    // Reset gives the identity matrix, 1.0 = 2^FRAC_BITS
    localparam logic [REG_W-1:0] ONE_LO     = REG_W'(64'd1 << FRAC_BITS);
    localparam logic [REG_W-1:0] ONE_HI     = REG_W'(64'd1 << (FRAC_BITS + SLOT_W));
    localparam logic [REG_W-1:0] RST_ROW0_XY = ONE_LO;
    localparam logic [REG_W-1:0] RST_ROW0_ZW = '0;
    localparam logic [REG_W-1:0] RST_ROW1_XY = ONE_HI;
    localparam logic [REG_W-1:0] RST_ROW1_ZW = '0;
    localparam logic [REG_W-1:0] RST_ROW2_XY = '0;
    localparam logic [REG_W-1:0] RST_ROW2_ZW = ONE_LO;
    localparam logic [REG_W-1:0] RST_ROW3_XY = '0;
    localparam logic [REG_W-1:0] RST_ROW3_ZW = ONE_HI;

    typedef enum logic [KIND_W-1:0] {
        KIND_ORDINARY = 2'd0,
        KIND_NULL     = 2'd1,
        KIND_INFINITE = 2'd2,
        KIND_SPARE    = 2'd3
    } box_kind_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] nx;
        logic signed [COEF_W-1:0] ny;
        logic signed [COEF_W-1:0] nz;
        logic signed [COEF_W-1:0] d;
    } plane_t;

    typedef plane_t [NUM_PLANES-1:0] plane_vec_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] max_z;
        logic signed [COORD_WIDTH-1:0] max_y;
        logic signed [COORD_WIDTH-1:0] max_x;
        logic signed [COORD_WIDTH-1:0] min_z;
        logic signed [COORD_WIDTH-1:0] min_y;
        logic signed [COORD_WIDTH-1:0] min_x;
    } box_t;

    // Fixed-point value from the low COORD_WIDTH bits of a 32-bit slot
    function automatic logic signed [COORD_WIDTH-1:0] slot_value(input logic [SLOT_W-1:0] slot);
        return signed'(slot[COORD_WIDTH-1:0]);
    endfunction

endpackage

`default_nettype wire

### rtl/fbc_cfg_regs.sv
// Matrix register file with plane coefficient extraction.
`default_nettype none

module fbc_cfg_regs
    import fbc_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [ADDR_W-1:0]   paddr,
    input  wire  [REG_W-1:0]    pwdata,
    output logic [REG_W-1:0]    prdata,
    output logic                pready,
    output plane_vec_t          planes,
    output logic                usable
);

    logic [REG_W-1:0] mat_reg [NUM_REGS];
    plane_vec_t       plane_reg, plane_next;
    logic             usable_reg, usable_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel & penable & pwrite & pready;
    assign pready  = 1'b1;
    assign prdata  = mat_reg[reg_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg[REG_ROW0_XY] <= RST_ROW0_XY;
            mat_reg[REG_ROW0_ZW] <= RST_ROW0_ZW;
            mat_reg[REG_ROW1_XY] <= RST_ROW1_XY;
            mat_reg[REG_ROW1_ZW] <= RST_ROW1_ZW;
            mat_reg[REG_ROW2_XY] <= RST_ROW2_XY;
            mat_reg[REG_ROW2_ZW] <= RST_ROW2_ZW;
            mat_reg[REG_ROW3_XY] <= RST_ROW3_XY;
            mat_reg[REG_ROW3_ZW] <= RST_ROW3_ZW;
        end else if (wr_en) begin
            mat_reg[reg_idx] <= pwdata;
        end
    end

    // Planes are row3 + row k and row3 - row k; column c lives in register {row, c[1]}
    always_comb begin
        logic signed [COORD_WIDTH-1:0] a_val;
        logic signed [COORD_WIDTH-1:0] b_val;
        logic signed [COEF_W-1:0]      coef [4];
        plane_next  = plane_reg;
        usable_next = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++) begin
            for (int c = 0; c < 4; c++) begin
                a_val = slot_value(mat_reg[{2'd3, c[1]}][c[0]*SLOT_W +: SLOT_W]);
                b_val = slot_value(mat_reg[{2'(i >> 1), c[1]}][c[0]*SLOT_W +: SLOT_W]);
                if (i[0]) begin
                    coef[c] = COEF_W'(a_val) - COEF_W'(b_val);
                end else begin
                    coef[c] = COEF_W'(a_val) + COEF_W'(b_val);
                end
            end
            plane_next[i].nx = coef[0];
            plane_next[i].ny = coef[1];
            plane_next[i].nz = coef[2];
            plane_next[i].d  = coef[3];
            if (coef[0] == '0 && coef[1] == '0 && coef[2] == '0) begin
                usable_next = 1'b0;
            end
        end
    end

    // Register the planes and usable flag so they follow the matrix
    always_ff @(posedge aclk) begin
        plane_reg  <= plane_next;
        usable_reg <= usable_next;
    end

    assign planes = plane_reg;
    assign usable = usable_reg;

endmodule

`default_nettype wire

### rtl/fbc_plane_test.sv
// Positive-vertex test of one box against one plane, products registered.
`default_nettype none

module fbc_plane_test
    import fbc_pkg::*;
(
    input  wire          aclk,
    input  wire          en,
    input  wire plane_t  plane,
    input  wire box_t    box,
    output logic         behind
);

    logic signed [COORD_WIDTH-1:0] px, py, pz;
    logic signed [PROD_W-1:0]      prod_x_next, prod_y_next, prod_z_next;
    logic signed [PROD_W-1:0]      prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [COEF_W-1:0]      d_reg;
    logic signed [SUM_W-1:0]       d_ext;
    logic signed [SUM_W-1:0]       sum;

    // Pick the corner furthest along the normal
    assign px = plane.nx[COEF_W-1] ? box.min_x : box.max_x;
    assign py = plane.ny[COEF_W-1] ? box.min_y : box.max_y;
    assign pz = plane.nz[COEF_W-1] ? box.min_z : box.max_z;

    assign prod_x_next = plane.nx * px;
    assign prod_y_next = plane.ny * py;
    assign prod_z_next = plane.nz * pz;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            d_reg      <= plane.d;
        end
    end

    // Products carry 2*FRAC_BITS fraction bits, so scale d to match
    assign d_ext  = SUM_W'(d_reg);
    assign sum    = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg) + SUM_W'(prod_z_reg)
                  + (d_ext <<< FRAC_BITS);
    assign behind = sum[SUM_W-1];

endmodule

`default_nettype wire

### rtl/frustum_box_cull.sv
// Top level: view-frustum cull of axis-aligned boxes, one box per cycle unless stalled.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tdata: box min x,y,z, max x,y,z; tuser: box_kind
//  m_       out  m_tvalid/m_tready  tdata: may_intersect; tuser: frustum_usable
//  cfg      in   APB psel/penable   eight 64-bit matrix registers at 8*i
//
// One box per cycle unless m_tready stalls the output; a result passes through the
// input register, product register and result register.
// Eighteen 33x32 multipliers, then one 67-bit sum per plane, set the cycle.
// A one-entry skid holds an item while the output stalls; s_tready is registered.
// Synchronous active-low reset clears all valid flags; the matrix returns to identity.
`default_nettype none

module frustum_box_cull
    import fbc_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [BOX_DATA_W-1:0]   s_tdata,   // min_x, min_y, min_z, max_x, max_y, max_z
    input  wire  [KIND_W-1:0]       s_tuser,   // box_kind
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,   // may_intersect, zero fill
    output logic                    m_tuser,   // frustum_usable
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [ADDR_W-1:0]       paddr,
    input  wire  [REG_W-1:0]        pwdata,
    output logic [REG_W-1:0]        prdata,
    output logic                    pready
);

    plane_vec_t planes;
    logic       usable;
    logic       en;
    logic       s_hs;

    box_t                 s_box;
    logic                 skid_valid_reg, skid_valid_next;
    box_t                 skid_box_reg;
    logic [KIND_W-1:0]    skid_kind_reg;
    logic                 ready_reg, ready_next;

    logic                 v1_reg, v1_next;
    box_t                 box1_reg;
    logic [KIND_W-1:0]    kind1_reg;
    logic                 v2_reg;
    logic [KIND_W-1:0]    kind2_reg;

    logic [NUM_PLANES-1:0] behind;
    logic                 hit;
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic                 usable_reg;

    fbc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes),
        .usable  (usable)
    );

    for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
        fbc_plane_test u_test (
            .aclk   (aclk),
            .en     (en),
            .plane  (planes[i]),
            .box    (box1_reg),
            .behind (behind[i])
        );
    end

    assign s_box.min_x = slot_value(s_tdata[0*32 +: 32]);
    assign s_box.min_y = slot_value(s_tdata[1*32 +: 32]);
    assign s_box.min_z = slot_value(s_tdata[2*32 +: 32]);
    assign s_box.max_x = slot_value(s_tdata[3*32 +: 32]);
    assign s_box.max_y = slot_value(s_tdata[4*32 +: 32]);
    assign s_box.max_z = slot_value(s_tdata[5*32 +: 32]);

    // Whole pipeline advances when the result register is free or being taken
    assign en       = !out_valid_reg || m_tready;
    assign s_hs     = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb begin
        if (en) begin
            skid_valid_next = 1'b0;
        end else if (s_hs) begin
            skid_valid_next = 1'b1;
        end else begin
            skid_valid_next = skid_valid_reg;
        end
        ready_next = !skid_valid_next;
        v1_next    = skid_valid_reg || s_hs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            ready_reg      <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            ready_reg      <= ready_next;
            if (en) begin
                v1_reg        <= v1_next;
                v2_reg        <= v1_reg;
                out_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_hs) begin
            skid_box_reg  <= s_box;
            skid_kind_reg <= s_tuser;
        end
        if (en) begin
            box1_reg  <= skid_valid_reg ? skid_box_reg : s_box;
            kind1_reg <= skid_valid_reg ? skid_kind_reg : s_tuser;
            kind2_reg <= kind1_reg;
            hit_reg    <= hit;
            usable_reg <= usable;
        end
    end

    // Degenerate frustum or infinite box passes; null box fails; else all planes decide
    always_comb begin
        if (!usable || kind2_reg == KIND_INFINITE) begin
            hit = 1'b1;
        end else if (kind2_reg == KIND_NULL) begin
            hit = 1'b0;
        end else begin
            hit = ~|behind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, hit_reg};
    assign m_tuser  = usable_reg;

    a_unusable_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tdata[0])
        else $error("box culled by an unusable frustum");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !en) |=> (skid_valid_reg && $stable(skid_box_reg)))
        else $error("skid item lost or changed during stall");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && en) |=> v2_reg)
        else $error("item dropped between input and product stage");

    a_ready_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && !en && s_tvalid) |=> (skid_valid_reg && !s_tready))
        else $error("stalled item not caught by skid");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s_tready))
        else $error("valid or ready set right after reset");

endmodule

`default_nettype wire
